>>> hdl/range_unique_count_engine_defines.svh
// assertion macros shared by the range unique count engine
// no dependencies; included by files that carry concurrent checks
`ifndef RANGE_UNIQUE_COUNT_ENGINE_DEFINES_SVH
`define RANGE_UNIQUE_COUNT_ENGINE_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define RUCNT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rucnt check failed");

// next-cycle implication, disabled while reset is high
`define RUCNT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rucnt check failed");

`endif

>>> hdl/rucnt_pkg.sv
// shared types and constants for the range unique count engine
// no dependencies; imported by rucnt_tally and range_unique_count_engine
package rucnt_pkg;

   // field widths of the transfer ports
   localparam int POS_W = 10;
   localparam int VAL_W = 10;
   localparam int END_W = 11;
   localparam int CNT_W = 11;

   // positions and values the ports can carry
   localparam int POS_SPAN = 1 << POS_W;
   localparam int VAL_SPAN = 1 << VAL_W;

   // request function codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // element steps of the walker
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_LDEC   = 3'd0;
   localparam logic [STEP_W-1:0] STEP_RINC   = 3'd1;
   localparam logic [STEP_W-1:0] STEP_LINC   = 3'd2;
   localparam logic [STEP_W-1:0] STEP_RDEC   = 3'd3;
   localparam logic [STEP_W-1:0] STEP_WLEAVE = 3'd4;
   localparam logic [STEP_W-1:0] STEP_WENTER = 3'd5;

   // command from the walker to the count memory
   typedef struct packed {
      logic clr;
      logic rd;
      logic upd;
      logic leave;
   } cnt_cmd_type;

endpackage

>>> hdl/rucnt_tally.sv
// occurrence count memory and exactly-once tally with read-modify-write
// depends on rucnt_pkg for the command struct and count width
module rucnt_tally
   import rucnt_pkg::*;
#(
   parameter int CNT_DEPTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cnt_cmd_type                  cmd,
   input  logic [$clog2(CNT_DEPTH)-1:0] addr,
   output logic [CNT_W-1:0]             tally
);

   localparam int CAW = $clog2(CNT_DEPTH);

   logic [CNT_W-1:0] cnt_mem [CNT_DEPTH];
   logic [CNT_W-1:0] cnt_q_ff;
   logic [CAW-1:0]   addr_ff;
   logic [CNT_W-1:0] tally_ff;
   logic [CNT_W-1:0] tally_in;
   logic [CNT_W-1:0] cnt_wr_data;

   // count update and tally adjustment for one element entering or leaving
   always_comb begin
      tally_in    = tally_ff;
      cnt_wr_data = cnt_q_ff;
      if (cmd.leave) begin
         if (cnt_q_ff != '0) begin
            cnt_wr_data = cnt_q_ff - CNT_W'(1);
            if (cnt_q_ff == CNT_W'(1)) begin
               tally_in = tally_ff - CNT_W'(1);
            end else if (cnt_q_ff == CNT_W'(2)) begin
               tally_in = tally_ff + CNT_W'(1);
            end
         end
      end else begin
         cnt_wr_data = cnt_q_ff + CNT_W'(1);
         if (cnt_q_ff == '0) begin
            tally_in = tally_ff + CNT_W'(1);
         end else if (cnt_q_ff == CNT_W'(1)) begin
            tally_in = tally_ff - CNT_W'(1);
         end
      end
   end

   // memory port: clear or write back, registered read
   always_ff @(posedge clock) begin
      if (cmd.clr) begin
         cnt_mem[addr] <= '0;
      end else if (cmd.upd) begin
         cnt_mem[addr_ff] <= cnt_wr_data;
      end
      if (cmd.rd) begin
         cnt_q_ff <= cnt_mem[addr];
         addr_ff  <= addr;
      end
   end

   // tally register
   always_ff @(posedge clock) begin
      if (reset) begin
         tally_ff <= '0;
      end else if (cmd.upd) begin
         tally_ff <= tally_in;
      end
   end

   assign tally = tally_ff;

endmodule

>>> hdl/range_unique_count_engine.sv
// top level of the range unique count engine: value array, window walker
// depends on rucnt_pkg, rucnt_tally and range_unique_count_engine_defines.svh
//
// Usage: a request is taken at a clock edge with start high and busy low.
// req_func selects a write (store req_value at req_position) or a query of
// the window [req_position, req_right_end). Each query gives one result,
// shown on rsp_unique_count and rsp_bad_range for exactly one cycle while
// rsp_valid is high; writes give no result. The receiver cannot stall.
// Timing: a reversed query answers in the next cycle. Any other query walks
// the window one element at a time through the value array and the count
// memory, each element moved taking a step decision, an array read, a
// count read and a write back, and its result strobes once both ends have
// reached the target bounds. A write outside the window only stores the
// value; one inside it also counts the old element out and the new one in.
// busy stays high until the next request can be taken.
// After reset a clearing pass zeroes both memories, with busy held high.
`include "range_unique_count_engine_defines.svh"

module range_unique_count_engine
   import rucnt_pkg::*;
#(
   parameter int ARRAY_SIZE  = 1024,
   parameter int VALUE_RANGE = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic             req_func,
   input  logic [POS_W-1:0] req_position,
   input  logic [VAL_W-1:0] req_value,
   input  logic [END_W-1:0] req_right_end,
   output logic             rsp_valid,
   output logic [CNT_W-1:0] rsp_unique_count,
   output logic             rsp_bad_range
);

   // only positions and values the ports can carry need storage
   localparam int ARR_DEPTH = (ARRAY_SIZE < POS_SPAN) ? ARRAY_SIZE : POS_SPAN;
   localparam int CNT_DEPTH = (VALUE_RANGE < VAL_SPAN) ? VALUE_RANGE : VAL_SPAN;
   localparam int CLR_DEPTH = (ARR_DEPTH > CNT_DEPTH) ? ARR_DEPTH : CNT_DEPTH;
   localparam int AAW = $clog2(ARR_DEPTH);
   localparam int CAW = $clog2(CNT_DEPTH);
   localparam int CLW = $clog2(CLR_DEPTH);
   localparam logic [16:0] ASZ = 17'(ARRAY_SIZE);
   localparam logic [16:0] VSZ = 17'(VALUE_RANGE);

   // controller states
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_PLAN  = 3'd2;
   localparam logic [2:0] S_ARD   = 3'd3;
   localparam logic [2:0] S_CRD   = 3'd4;
   localparam logic [2:0] S_UPD   = 3'd5;
   localparam logic [2:0] S_WRITE = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [END_W-1:0]  win_left_ff, win_left_in;
   logic [END_W-1:0]  win_right_ff, win_right_in;
   logic [END_W-1:0]  tgt_left_ff, tgt_left_in;
   logic [END_W-1:0]  tgt_right_ff, tgt_right_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [END_W-1:0]  idx_ff, idx_in;
   logic [AAW-1:0]    wr_pos_ff, wr_pos_in;
   logic [VAL_W-1:0]  wr_val_ff, wr_val_in;
   logic              inside_ff, inside_in;
   logic [CLW-1:0]    clr_ff, clr_in;
   logic [VAL_W-1:0]  arr_q_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic              rsp_bad_ff, rsp_bad_in;

   logic [VAL_W-1:0]  arr_mem [ARR_DEPTH];
   logic              arr_rd_en;
   logic              arr_wr_en;
   logic [AAW-1:0]    arr_wr_addr;
   logic [VAL_W-1:0]  arr_wr_data;

   cnt_cmd_type       cnt_cmd;
   logic [CAW-1:0]    cnt_addr;
   logic [CNT_W-1:0]  tally;

   logic              accept;
   logic [16:0]       pos17;
   logic [16:0]       end17;
   logic [END_W-1:0]  pos_ext;
   logic              idx_in_arr;
   logic [VAL_W-1:0]  elem_val;
   logic              step_leave;

   assign accept  = start && (state_ff == S_IDLE);
   assign pos17   = 17'(req_position);
   assign end17   = 17'(req_right_end);
   assign pos_ext = END_W'(req_position);

   // indexes past the stored part of the array always hold zero
   assign idx_in_arr = idx_ff < END_W'(ARR_DEPTH);
   assign elem_val   = idx_in_arr ? arr_q_ff : '0;
   assign step_leave = (step_ff == STEP_LINC) || (step_ff == STEP_RDEC) ||
                       (step_ff == STEP_WLEAVE);

   // controller
   always_comb begin
      state_in     = state_ff;
      win_left_in  = win_left_ff;
      win_right_in = win_right_ff;
      tgt_left_in  = tgt_left_ff;
      tgt_right_in = tgt_right_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      wr_pos_in    = wr_pos_ff;
      wr_val_in    = wr_val_ff;
      inside_in    = inside_ff;
      clr_in       = clr_ff;
      rsp_valid_in = 1'b0;
      rsp_count_in = rsp_count_ff;
      rsp_bad_in   = rsp_bad_ff;
      arr_rd_en    = 1'b0;
      arr_wr_en    = 1'b0;
      arr_wr_addr  = wr_pos_ff;
      arr_wr_data  = wr_val_ff;
      cnt_cmd      = '0;
      cnt_addr     = elem_val[CAW-1:0];

      case (state_ff)
         // zero both memories after reset
         S_CLEAR: begin
            arr_wr_en   = {1'b0, clr_ff} < (CLW+1)'(ARR_DEPTH);
            arr_wr_addr = clr_ff[AAW-1:0];
            arr_wr_data = '0;
            cnt_cmd.clr = {1'b0, clr_ff} < (CLW+1)'(CNT_DEPTH);
            cnt_addr    = clr_ff[CAW-1:0];
            clr_in      = clr_ff + CLW'(1);
            if (clr_ff == CLW'(CLR_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         // take a request
         S_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_WRITE) begin
                  if ((pos17 < ASZ) && (17'(req_value) < VSZ)) begin
                     wr_pos_in = req_position[AAW-1:0];
                     wr_val_in = req_value;
                     inside_in = (win_left_ff <= pos_ext) && (pos_ext < win_right_ff);
                     if ((win_left_ff <= pos_ext) && (pos_ext < win_right_ff)) begin
                        step_in  = STEP_WLEAVE;
                        idx_in   = pos_ext;
                        state_in = S_ARD;
                     end else begin
                        state_in = S_WRITE;
                     end
                  end
               end else if (pos_ext > req_right_end) begin
                  rsp_valid_in = 1'b1;
                  rsp_count_in = '0;
                  rsp_bad_in   = 1'b1;
               end else begin
                  tgt_left_in  = (pos17 > ASZ) ? ASZ[END_W-1:0] : pos_ext;
                  tgt_right_in = (end17 > ASZ) ? ASZ[END_W-1:0] : req_right_end;
                  state_in     = S_PLAN;
               end
            end
         end
         // pick the next window step, or answer
         S_PLAN: begin
            state_in = S_ARD;
            if (win_left_ff > tgt_left_ff) begin
               step_in = STEP_LDEC;
               idx_in  = win_left_ff - END_W'(1);
            end else if (win_right_ff < tgt_right_ff) begin
               step_in = STEP_RINC;
               idx_in  = win_right_ff;
            end else if (win_left_ff < tgt_left_ff) begin
               step_in = STEP_LINC;
               idx_in  = win_left_ff;
            end else if (win_right_ff > tgt_right_ff) begin
               step_in = STEP_RDEC;
               idx_in  = win_right_ff - END_W'(1);
            end else begin
               rsp_valid_in = 1'b1;
               rsp_count_in = tally;
               rsp_bad_in   = 1'b0;
               state_in     = S_IDLE;
            end
         end
         // read the element value
         S_ARD: begin
            arr_rd_en = idx_in_arr;
            state_in  = S_CRD;
         end
         // read the count of that value
         S_CRD: begin
            cnt_cmd.rd = 1'b1;
            cnt_addr   = elem_val[CAW-1:0];
            state_in   = S_UPD;
         end
         // write the count back and move the window end
         S_UPD: begin
            cnt_cmd.upd   = 1'b1;
            cnt_cmd.leave = step_leave;
            case (step_ff)
               STEP_LDEC:   win_left_in  = win_left_ff - END_W'(1);
               STEP_RINC:   win_right_in = win_right_ff + END_W'(1);
               STEP_LINC:   win_left_in  = win_left_ff + END_W'(1);
               STEP_RDEC:   win_right_in = win_right_ff - END_W'(1);
               default: ;
            endcase
            if (step_ff == STEP_WLEAVE) begin
               state_in = S_WRITE;
            end else if (step_ff == STEP_WENTER) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_PLAN;
            end
         end
         // store the new value, then count it in if inside the window
         S_WRITE: begin
            arr_wr_en = 1'b1;
            if (inside_ff) begin
               step_in  = STEP_WENTER;
               state_in = S_ARD;
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // value array: one write port, registered read
   always_ff @(posedge clock) begin
      if (arr_wr_en) begin
         arr_mem[arr_wr_addr] <= arr_wr_data;
      end
      if (arr_rd_en) begin
         arr_q_ff <= arr_mem[idx_ff[AAW-1:0]];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         win_left_ff  <= '0;
         win_right_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         win_left_ff  <= win_left_in;
         win_right_ff <= win_right_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      tgt_left_ff  <= tgt_left_in;
      tgt_right_ff <= tgt_right_in;
      step_ff      <= step_in;
      idx_ff       <= idx_in;
      wr_pos_ff    <= wr_pos_in;
      wr_val_ff    <= wr_val_in;
      inside_ff    <= inside_in;
      rsp_count_ff <= rsp_count_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   // count memory and tally
   rucnt_tally #(
      .CNT_DEPTH (CNT_DEPTH)
   ) u_tally (
      .clock (clock),
      .reset (reset),
      .cmd   (cnt_cmd),
      .addr  (cnt_addr),
      .tally (tally)
   );

   assign busy             = state_ff != S_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_unique_count = rsp_count_ff;
   assign rsp_bad_range    = rsp_bad_ff;

   // checks
   `RUCNT_ASSERT_NEXT(a_bad_range_answer, clock, reset,
      accept && (req_func == FUNC_QUERY) && (pos_ext > req_right_end),
      rsp_valid_ff && rsp_bad_ff && (rsp_count_ff == '0))
   `RUCNT_ASSERT_SAME(a_good_answer_from_plan, clock, reset,
      rsp_valid_ff && !rsp_bad_ff, $past(state_ff) == S_PLAN)
   `RUCNT_ASSERT_SAME(a_window_in_array, clock, reset,
      1'b1, (17'(win_left_ff) <= ASZ) && (17'(win_right_ff) <= ASZ))
   `RUCNT_ASSERT_SAME(a_update_after_read, clock, reset,
      state_ff == S_UPD, $past(state_ff) == S_CRD)

endmodule
